// ===== rtl/core/vssp_pkg.sv =====
package vssp_pkg;

    localparam logic [3:0] PH_HDR_LEN    = 4'd0;
    localparam logic [3:0] PH_HDR_DATA   = 4'd1;
    localparam logic [3:0] PH_TAG        = 4'd2;
    localparam logic [3:0] PH_TITLE_LEN  = 4'd3;
    localparam logic [3:0] PH_TITLE_CHAR = 4'd4;
    localparam logic [3:0] PH_TITLE_DONE = 4'd5;
    localparam logic [3:0] PH_NUM_LEN    = 4'd6;
    localparam logic [3:0] PH_NUM_DATA   = 4'd7;
    localparam logic [3:0] PH_COL_LEN    = 4'd8;
    localparam logic [3:0] PH_COL_DATA   = 4'd9;

    localparam logic [3:0] KIND_HEADER     = 4'd0;
    localparam logic [3:0] KIND_TITLE      = 4'd1;
    localparam logic [3:0] KIND_BACKGROUND = 4'd2;
    localparam logic [3:0] KIND_CIRCLE     = 4'd3;
    localparam logic [3:0] KIND_RECT       = 4'd4;
    localparam logic [3:0] KIND_OVAL       = 4'd5;
    localparam logic [3:0] KIND_LINE       = 4'd6;
    localparam logic [3:0] KIND_TRIANGLE   = 4'd7;
    localparam logic [3:0] KIND_POLYGON    = 4'd8;
    localparam logic [3:0] KIND_QUAD       = 4'd9;
    localparam logic [3:0] KIND_CUBIC      = 4'd10;

    localparam logic [7:0] TAG_TITLE      = 8'd0;
    localparam logic [7:0] TAG_BACKGROUND = 8'd1;
    localparam logic [7:0] TAG_LAST       = 8'd9;

    localparam logic [2:0] FLD_COUNT   = 3'd0;
    localparam logic [2:0] FLD_PT_X    = 3'd1;
    localparam logic [2:0] FLD_PT_Y    = 3'd2;
    localparam logic [2:0] FLD_THICK   = 3'd3;
    localparam logic [2:0] FLD_BEZ_COL = 3'd4;
    localparam logic [2:0] FLD_HDR_RATE = 3'd2;

    localparam logic [31:0] COLOUR_DEFAULT = 32'h0000_00FF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  fld;
        logic [31:0] pidx;
        logic [31:0] value;
        logic        last;
    } res_t;

    function automatic logic [2:0] plain_numbers(input logic [3:0] kind);
        logic [2:0] n;
        begin
            unique case (kind)
                KIND_CIRCLE:   n = 3'd3;
                KIND_RECT:     n = 3'd4;
                KIND_OVAL:     n = 3'd4;
                KIND_LINE:     n = 3'd4;
                KIND_TRIANGLE: n = 3'd6;
                KIND_POLYGON:  n = 3'd5;
                default:       n = 3'd0;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== rtl/core/vssp_front.sv =====
module vssp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_fire,
    input  logic [7:0]    byte_in,
    output logic          res_push,
    output vssp_pkg::res_t res
);
    import vssp_pkg::*;

    logic [3:0]  phase_reg,  phase_next;
    logic [3:0]  kind_reg,   kind_next;
    logic [2:0]  fld_reg,    fld_next;
    logic [7:0]  left_reg,   left_next;
    logic [31:0] acc_reg,    acc_next;
    logic [31:0] pcnt_reg,   pcnt_next;
    logic [31:0] ptot_reg,   ptot_next;
    logic [31:0] col_reg,    col_next;
    logic [2:0]  cpos_reg,   cpos_next;

    logic [31:0] acc_shift;
    logic [7:0]  left_m1;
    logic [31:0] pcnt_p1;
    logic [31:0] done_val;
    logic [31:0] bez_total;
    logic        hdr_done, num_done, col_done, tag_start, bez;

    assign acc_shift = {acc_reg[23:0], 8'h00} + {24'd0, byte_in};
    assign left_m1   = left_reg - 8'd1;
    assign pcnt_p1   = pcnt_reg + 32'd1;
    assign bez       = (kind_reg == KIND_QUAD) || (kind_reg == KIND_CUBIC);
    assign bez_total = (kind_reg == KIND_QUAD) ? ({done_val[30:0], 1'b0} + done_val)
                                               : {done_val[29:0], 2'b00};

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        fld_next   = fld_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        pcnt_next  = pcnt_reg;
        ptot_next  = ptot_reg;
        col_next   = col_reg;
        cpos_next  = cpos_reg;
        res_push   = 1'b0;
        res        = '0;
        hdr_done   = 1'b0;
        num_done   = 1'b0;
        col_done   = 1'b0;
        tag_start  = 1'b0;
        done_val   = acc_shift;
        if (byte_fire)
        begin
            unique case (phase_reg)
                PH_HDR_LEN, PH_NUM_LEN:
                begin
                    acc_next  = '0;
                    left_next = byte_in;
                    done_val  = '0;
                    if (byte_in == 8'd0)
                    begin
                        hdr_done = (phase_reg == PH_HDR_LEN);
                        num_done = (phase_reg == PH_NUM_LEN);
                    end
                    else
                    begin
                        phase_next = (phase_reg == PH_HDR_LEN) ? PH_HDR_DATA : PH_NUM_DATA;
                    end
                end
                PH_HDR_DATA, PH_NUM_DATA:
                begin
                    acc_next  = acc_shift;
                    left_next = left_m1;
                    if (left_m1 == 8'd0)
                    begin
                        hdr_done = (phase_reg == PH_HDR_DATA);
                        num_done = (phase_reg == PH_NUM_DATA);
                    end
                end
                PH_TITLE_DONE:
                begin
                    res_push  = 1'b1;
                    res       = '{kind: KIND_TITLE, fld: 3'd0, pidx: pcnt_reg,
                                  value: 32'd0, last: 1'b1};
                    tag_start = 1'b1;
                end
                PH_TITLE_LEN:
                begin
                    ptot_next = {24'd0, byte_in};
                    pcnt_next = '0;
                    if (byte_in == 8'd0)
                    begin
                        res_push   = 1'b1;
                        res        = '{kind: KIND_TITLE, fld: 3'd0, pidx: 32'd0,
                                       value: 32'd0, last: 1'b1};
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        phase_next = PH_TITLE_CHAR;
                    end
                end
                PH_TITLE_CHAR:
                begin
                    res_push  = 1'b1;
                    res       = '{kind: KIND_TITLE, fld: 3'd0, pidx: pcnt_reg,
                                  value: {24'd0, byte_in}, last: 1'b0};
                    pcnt_next = pcnt_p1;
                    if (pcnt_p1 >= ptot_reg)
                    begin
                        phase_next = PH_TITLE_DONE;
                    end
                end
                PH_COL_LEN:
                begin
                    col_next  = COLOUR_DEFAULT;
                    cpos_next = '0;
                    left_next = byte_in;
                    if (byte_in == 8'd0)
                    begin
                        col_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_COL_DATA;
                    end
                end
                PH_COL_DATA:
                begin
                    if (!cpos_reg[2])
                    begin
                        unique case (cpos_reg[1:0])
                            2'd0: col_next[31:24] = byte_in;
                            2'd1: col_next[23:16] = byte_in;
                            2'd2: col_next[15:8]  = byte_in;
                            default: col_next[7:0] = byte_in;
                        endcase
                        cpos_next = cpos_reg + 3'd1;
                    end
                    left_next = left_m1;
                    col_done  = (left_m1 == 8'd0);
                end
                default:
                begin
                    tag_start = 1'b1;
                end
            endcase

            if (hdr_done)
            begin
                res_push = 1'b1;
                res      = '{kind: KIND_HEADER, fld: fld_reg, pidx: 32'd0,
                             value: done_val, last: (fld_reg >= FLD_HDR_RATE)};
                if (fld_reg >= FLD_HDR_RATE)
                begin
                    fld_next   = '0;
                    phase_next = PH_TAG;
                end
                else
                begin
                    fld_next   = fld_reg + 3'd1;
                    phase_next = PH_HDR_LEN;
                end
            end

            if (num_done)
            begin
                res_push = 1'b1;
                res      = '{kind: kind_reg, fld: fld_reg,
                             pidx: (bez && (fld_reg == FLD_PT_X || fld_reg == FLD_PT_Y))
                                   ? pcnt_reg : 32'd0,
                             value: done_val, last: 1'b0};
                phase_next = PH_NUM_LEN;
                if (bez)
                begin
                    priority if (fld_reg == FLD_COUNT)
                    begin
                        ptot_next = bez_total;
                        pcnt_next = '0;
                        fld_next  = (bez_total != 32'd0) ? FLD_PT_X : FLD_THICK;
                    end
                    else if (fld_reg == FLD_PT_X)
                    begin
                        fld_next = FLD_PT_Y;
                    end
                    else if (fld_reg == FLD_PT_Y)
                    begin
                        pcnt_next = pcnt_p1;
                        fld_next  = (pcnt_p1 != ptot_reg) ? FLD_PT_X : FLD_THICK;
                    end
                    else
                    begin
                        fld_next   = FLD_BEZ_COL;
                        phase_next = PH_COL_LEN;
                    end
                end
                else
                begin
                    fld_next = fld_reg + 3'd1;
                    if ((fld_reg + 3'd1) >= plain_numbers(kind_reg))
                    begin
                        phase_next = PH_COL_LEN;
                    end
                end
            end

            if (col_done)
            begin
                res_push   = 1'b1;
                res        = '{kind: kind_reg, fld: fld_reg, pidx: 32'd0,
                               value: col_next, last: 1'b1};
                fld_next   = '0;
                phase_next = PH_TAG;
            end

            if (tag_start)
            begin
                priority if (byte_in == TAG_TITLE)
                begin
                    kind_next  = KIND_TITLE;
                    fld_next   = '0;
                    phase_next = PH_TITLE_LEN;
                end
                else if (byte_in == TAG_BACKGROUND)
                begin
                    kind_next  = KIND_BACKGROUND;
                    fld_next   = '0;
                    phase_next = PH_COL_LEN;
                end
                else if (byte_in <= TAG_LAST)
                begin
                    kind_next  = byte_in[3:0] + 4'd1;
                    fld_next   = '0;
                    pcnt_next  = '0;
                    ptot_next  = '0;
                    phase_next = PH_NUM_LEN;
                end
                else
                begin
                    phase_next = PH_TAG;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR_LEN;
            kind_reg  <= KIND_HEADER;
            fld_reg   <= '0;
            left_reg  <= '0;
            acc_reg   <= '0;
            pcnt_reg  <= '0;
            ptot_reg  <= '0;
            col_reg   <= COLOUR_DEFAULT;
            cpos_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            fld_reg   <= fld_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            pcnt_reg  <= pcnt_next;
            ptot_reg  <= ptot_next;
            col_reg   <= col_next;
            cpos_reg  <= cpos_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> byte_fire)
        else $error("result pushed without an accepted byte");

    a_hdr_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_HEADER) |-> (res.last == (res.fld == FLD_HDR_RATE)))
        else $error("header record end on wrong field");

    a_hdr_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR_LEN || phase_reg == PH_HDR_DATA) |-> (kind_reg == KIND_HEADER))
        else $error("header phase with non-header kind");
`endif

endmodule

// ===== rtl/core/vssp_fifo.sv =====
module vssp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vssp_pkg::res_t push_data,
    input  logic           pop,
    output vssp_pkg::res_t head,
    output logic           empty,
    output logic           full
);
    import vssp_pkg::*;

    res_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == (QAW+1)'(QDEPTH));
    assign head    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign wr_next = do_push ? wr_reg + QAW'(1) : wr_reg;
    assign rd_next = do_pop ? rd_reg + QAW'(1) : rd_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (QAW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/vssp_back.sv =====
module vssp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  vssp_pkg::res_t head,
    input  logic           empty,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,
    output logic [6:0]     m_tuser,
    output logic           m_tlast
);
    import vssp_pkg::*;

    res_t out_reg;
    logic valid_reg, valid_next;

    assign pop        = !empty && (!valid_reg || m_tready);
    assign valid_next = pop ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_reg.value, out_reg.pidx};
    assign m_tuser  = {out_reg.fld, out_reg.kind};
    assign m_tlast  = out_reg.last;

endmodule

// ===== rtl/core/vector_scene_stream_parser.sv =====
// byte-serial parser for a shape-scene stream
// input: s_tdata carries one stream byte per request
// output: one request per decoded header number, title character, title
//   terminator, shape number or colour; tuser holds kind and field index,
//   tdata holds point index and value, tlast marks the end of a record
// a byte that completes nothing yields no output request
// throughput: one byte per cycle while s_tready is high; the parser front end
//   updates its state once per accepted byte
// path: a result is written into a 4-entry queue at the accepting edge and
//   then into the output register, which drives m_tvalid
// reset: expects the header width length byte; output empty, queue empty
// receiver stall: results collect in the queue and output register;
//   s_tready drops when the queue is full and rises as soon as room frees
module vector_scene_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // point_index [31:0], value [63:32]
    output logic [6:0]  m_tuser,   // record_kind [3:0], field_index [6:4]
    output logic        m_tlast    // record_end
);
    import vssp_pkg::*;

    res_t res;
    res_t head;
    logic res_push, byte_fire, empty, full, pop;

    assign s_tready  = !full;
    assign byte_fire = s_tvalid && s_tready;

    vssp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .byte_in   (s_tdata),
        .res_push  (res_push),
        .res       (res)
    );

    vssp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    vssp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
